[sv/srs_pkg.sv]
// shared types and constants for the sensor reading statistics block
// no dependencies; used by srs_ctrl, srs_datapath and sensor_reading_statistics

package srs_pkg;

    // batch size default
    localparam int MAX_READINGS_DEF = 128;

    // field widths
    localparam int READ_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int MEAN_W  = 15;
    localparam int CNT_OUT_W = 8;
    localparam int IDX_OUT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W   = 104;

    // divider steps, one quotient bit each
    localparam int DIV_STEPS = MEAN_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARNING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALERT    = 2'd3;

    // configuration reset values
    localparam logic [LIMIT_W-1:0] NORMAL_RST   = 15'd480;
    localparam logic [LIMIT_W-1:0] WARNING_RST  = 15'd640;
    localparam logic [LIMIT_W-1:0] CRITICAL_RST = 15'd960;
    localparam logic [LIMIT_W-1:0] ALERT_RST    = 15'd720;

    // level bins
    localparam int NUM_BINS = 4;
    localparam logic [1:0] BIN_NORMAL   = 2'd0;
    localparam logic [1:0] BIN_WARNING  = 2'd1;
    localparam logic [1:0] BIN_CRITICAL = 2'd2;
    localparam logic [1:0] BIN_SHUTDOWN = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic take;      // reading transaction accepted
        logic load;      // accepted reading closes the batch
        logic div_step;  // one divider iteration
    } srs_cmd_t;

endpackage

[sv/srs_ctrl.sv]
// controller state machine for the sensor reading statistics block
// depends on srs_pkg; drives srs_datapath through srs_cmd_t

module srs_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output srs_pkg::srs_cmd_t cmd
);

    localparam logic [1:0] ST_ACCUM  = 2'd0;
    localparam logic [1:0] ST_DIVIDE = 2'd1;
    localparam logic [1:0] ST_SEND   = 2'd2;

    localparam logic [srs_pkg::STEP_W-1:0] LAST_STEP =
        srs_pkg::STEP_W'(srs_pkg::DIV_STEPS - 1);

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [srs_pkg::STEP_W-1:0] step_reg;
    logic [srs_pkg::STEP_W-1:0] step_next;

    // handshake outputs and commands
    assign s_tready     = (state_reg == ST_ACCUM);
    assign m_tvalid     = (state_reg == ST_SEND);
    assign cmd.take     = s_tvalid && s_tready;
    assign cmd.load     = cmd.take && s_tlast;
    assign cmd.div_step = (state_reg == ST_DIVIDE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                step_next = '0;
                if (cmd.load)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (m_tready)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // input and output sides never open together
    a_sides_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output both open");

    // closing a batch starts the divider
    a_load_divides: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DIVIDE) && (step_reg == '0))
        else $error("batch close did not start divide");

    // the last divider step hands over to presenting the result
    a_divide_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) && (step_reg == LAST_STEP) |=> m_tvalid)
        else $error("divide did not end in result");

endmodule

[sv/srs_datapath.sv]
// accumulators, configuration registers, result registers and divider
// depends on srs_pkg; commanded by srs_ctrl

module srs_datapath
#(
    parameter int MAX_READINGS = srs_pkg::MAX_READINGS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  srs_pkg::srs_cmd_t                    cmd,
    input  logic signed [srs_pkg::READ_W-1:0]    reading,
    input  logic                                 cfg_write,
    input  logic [srs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [srs_pkg::LIMIT_W-1:0]          cfg_data,
    output logic [srs_pkg::OUT_W-1:0]            result
);

    localparam int CNT_W = $clog2(MAX_READINGS + 1);
    localparam int SUM_W = srs_pkg::MEAN_W + CNT_W;
    localparam int BIN_N = srs_pkg::NUM_BINS;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_READINGS);

    // configuration registers
    logic [srs_pkg::LIMIT_W-1:0] normal_reg;
    logic [srs_pkg::LIMIT_W-1:0] warning_reg;
    logic [srs_pkg::LIMIT_W-1:0] critical_reg;
    logic [srs_pkg::LIMIT_W-1:0] alert_reg;

    // accumulators
    logic [CNT_W-1:0]                    item_reg, item_next;
    logic [CNT_W-1:0]                    good_reg, good_next;
    logic [CNT_W-1:0]                    bad_reg, bad_next;
    logic [SUM_W-1:0]                    sum_reg, sum_next;
    logic signed [srs_pkg::READ_W-1:0]   min_reg, min_next;
    logic signed [srs_pkg::READ_W-1:0]   max_reg, max_next;
    logic [CNT_W-1:0]                    bin_reg [BIN_N];
    logic [CNT_W-1:0]                    bin_next [BIN_N];
    logic [srs_pkg::IDX_OUT_W-1:0]       aidx_reg, aidx_next;
    logic                                aseen_reg, aseen_next;
    logic                                ovf_reg, ovf_next;

    // batch results
    logic [CNT_W-1:0]                    res_good_reg;
    logic [CNT_W-1:0]                    res_bad_reg;
    logic signed [srs_pkg::READ_W-1:0]   res_min_reg;
    logic signed [srs_pkg::READ_W-1:0]   res_max_reg;
    logic [CNT_W-1:0]                    res_bin_reg [BIN_N];
    logic [srs_pkg::IDX_OUT_W-1:0]       res_aidx_reg;
    logic                                res_aseen_reg;
    logic                                res_ovf_reg;

    // divider: partial remainder and dividend/quotient shift register
    logic [CNT_W-1:0]                    rem_reg;
    logic [srs_pkg::MEAN_W-1:0]          quot_reg;
    logic [CNT_W:0]                      trial;
    logic                                q_bit;
    logic [srs_pkg::MEAN_W-1:0]          mean;

    // reading classification
    logic                                in_room;
    logic                                is_good;
    logic                                hit_alert;
    logic [1:0]                          bin_sel;

    assign in_room   = (item_reg < CNT_MAX);
    assign is_good   = !reading[srs_pkg::READ_W-1] && (reading != '0);
    assign hit_alert = !reading[srs_pkg::READ_W-1] &&
                       (reading[srs_pkg::LIMIT_W-1:0] >= alert_reg);

    // level bin, first limit not exceeded wins
    always_comb
    begin
        priority if (reading[srs_pkg::LIMIT_W-1:0] <= normal_reg)
            bin_sel = srs_pkg::BIN_NORMAL;
        else if (reading[srs_pkg::LIMIT_W-1:0] <= warning_reg)
            bin_sel = srs_pkg::BIN_WARNING;
        else if (reading[srs_pkg::LIMIT_W-1:0] <= critical_reg)
            bin_sel = srs_pkg::BIN_CRITICAL;
        else
            bin_sel = srs_pkg::BIN_SHUTDOWN;
    end

    // accumulator update for one reading
    always_comb
    begin
        item_next  = item_reg;
        good_next  = good_reg;
        bad_next   = bad_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        bin_next   = bin_reg;
        aidx_next  = aidx_reg;
        aseen_next = aseen_reg;
        ovf_next   = ovf_reg;
        if (cmd.take)
        begin
            if (!in_room)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                if (!aseen_reg && hit_alert)
                begin
                    aseen_next = 1'b1;
                    aidx_next  = srs_pkg::IDX_OUT_W'(item_reg);
                end
                item_next = item_reg + 1'b1;
                if (!is_good)
                begin
                    bad_next = bad_reg + 1'b1;
                end
                else
                begin
                    if ((good_reg == '0) || (reading < min_reg))
                        min_next = reading;
                    if ((good_reg == '0) || (reading > max_reg))
                        max_next = reading;
                    good_next = good_reg + 1'b1;
                    sum_next  = sum_reg + SUM_W'(reading[srs_pkg::LIMIT_W-1:0]);
                    bin_next[bin_sel] = bin_reg[bin_sel] + 1'b1;
                end
            end
        end
    end

    // accumulators, cleared when a batch closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg  <= '0;
            good_reg  <= '0;
            bad_reg   <= '0;
            sum_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            aidx_reg  <= '0;
            aseen_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < BIN_N; i++)
            begin
                bin_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            item_reg  <= '0;
            good_reg  <= '0;
            bad_reg   <= '0;
            sum_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            aidx_reg  <= '0;
            aseen_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            for (int i = 0; i < BIN_N; i++)
            begin
                bin_reg[i] <= '0;
            end
        end
        else
        begin
            item_reg  <= item_next;
            good_reg  <= good_next;
            bad_reg   <= bad_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            aidx_reg  <= aidx_next;
            aseen_reg <= aseen_next;
            ovf_reg   <= ovf_next;
            bin_reg   <= bin_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg   <= srs_pkg::NORMAL_RST;
            warning_reg  <= srs_pkg::WARNING_RST;
            critical_reg <= srs_pkg::CRITICAL_RST;
            alert_reg    <= srs_pkg::ALERT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                srs_pkg::CFG_NORMAL:   normal_reg   <= cfg_data;
                srs_pkg::CFG_WARNING:  warning_reg  <= cfg_data;
                srs_pkg::CFG_CRITICAL: critical_reg <= cfg_data;
                srs_pkg::CFG_ALERT:    alert_reg    <= cfg_data;
                default:               normal_reg   <= normal_reg;
            endcase
        end
    end

    // one restoring divide step
    assign trial = {rem_reg, quot_reg[srs_pkg::MEAN_W-1]};
    assign q_bit = (trial >= {1'b0, res_good_reg});

    // result capture and divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_good_reg  <= '0;
            res_bad_reg   <= '0;
            res_min_reg   <= '0;
            res_max_reg   <= '0;
            res_aidx_reg  <= '0;
            res_aseen_reg <= 1'b0;
            res_ovf_reg   <= 1'b0;
            rem_reg       <= '0;
            quot_reg      <= '0;
            for (int i = 0; i < BIN_N; i++)
            begin
                res_bin_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            res_good_reg  <= good_next;
            res_bad_reg   <= bad_next;
            res_min_reg   <= min_next;
            res_max_reg   <= max_next;
            res_bin_reg   <= bin_next;
            res_aidx_reg  <= aidx_next;
            res_aseen_reg <= aseen_next;
            res_ovf_reg   <= ovf_next;
            rem_reg       <= sum_next[SUM_W-1:srs_pkg::MEAN_W];
            quot_reg      <= sum_next[srs_pkg::MEAN_W-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= q_bit ? CNT_W'(trial - {1'b0, res_good_reg}) : trial[CNT_W-1:0];
            quot_reg <= {quot_reg[srs_pkg::MEAN_W-2:0], q_bit};
        end
    end

    // no valid readings gives a zero mean
    assign mean = (res_good_reg == '0) ? '0 : quot_reg;

    // packed result, first field highest
    assign result = {res_ovf_reg,
                     srs_pkg::CNT_OUT_W'(res_bin_reg[srs_pkg::BIN_SHUTDOWN]),
                     srs_pkg::CNT_OUT_W'(res_bin_reg[srs_pkg::BIN_CRITICAL]),
                     srs_pkg::CNT_OUT_W'(res_bin_reg[srs_pkg::BIN_WARNING]),
                     srs_pkg::CNT_OUT_W'(res_bin_reg[srs_pkg::BIN_NORMAL]),
                     res_aidx_reg,
                     res_aseen_reg,
                     mean,
                     res_max_reg,
                     res_min_reg,
                     srs_pkg::CNT_OUT_W'(res_bad_reg),
                     srs_pkg::CNT_OUT_W'(res_good_reg)};

    // every counted reading is either good or bad
    a_count_split: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(good_reg) + (CNT_W + 1)'(bad_reg) == (CNT_W + 1)'(item_reg))
        else $error("good and bad counts do not add up");

    // closing a batch leaves the accumulators clear
    a_clear_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (item_reg == '0) && (sum_reg == '0) && !ovf_reg && !aseen_reg)
        else $error("accumulators not cleared after batch");

endmodule

[sv/sensor_reading_statistics.sv]
// top level of the sensor reading statistics block
// depends on srs_pkg, srs_ctrl and srs_datapath
//
// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  s_tdata reading, s_tlast end of batch
// m_        out        m_tvalid / m_tready  m_tdata batch statistics
// cfg_      in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// one reading per cycle while a batch is open; the last reading starts a
// restoring divider that yields one mean bit per step, then the result
// is held on m_ until taken.
// no reading transaction is taken while the divider runs or the result waits.
// reset loads the default limits and clears all counters; config is always ready.

module sensor_reading_statistics
#(
    parameter int MAX_READINGS = srs_pkg::MAX_READINGS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [srs_pkg::READ_W-1:0]          s_tdata,   // [15:0] reading
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] valid_total, [15:8] error_total, [31:16] min_reading,
    // [47:32] max_reading, [62:48] mean_reading, [63] alert_found,
    // [70:64] alert_index, [78:71] normal_total, [86:79] warning_total,
    // [94:87] critical_total, [102:95] shutdown_total, [103] overflowed
    output logic [srs_pkg::OUT_W-1:0]           m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [srs_pkg::LIMIT_W-1:0]         cfg_data
);

    srs_pkg::srs_cmd_t cmd;

    // configuration writes complete at once
    assign cfg_ready = 1'b1;

    // controller
    srs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath
    srs_datapath #(
        .MAX_READINGS (MAX_READINGS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .reading   (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (m_tdata)
    );

endmodule

[sim/sensor_reading_statistics_tb.sv]
// self-checking testbench for sensor_reading_statistics: directed table, then random batches
// a behavioral predictor folds each accepted reading and queues the expected batch statistics
// depends on srs_pkg and sensor_reading_statistics

module sensor_reading_statistics_tb;

    // batch statistics as packed on m_tdata, msb first
    typedef struct packed {
        logic                          overflowed;
        logic [srs_pkg::CNT_OUT_W-1:0] shutdown_total;
        logic [srs_pkg::CNT_OUT_W-1:0] critical_total;
        logic [srs_pkg::CNT_OUT_W-1:0] warning_total;
        logic [srs_pkg::CNT_OUT_W-1:0] normal_total;
        logic [srs_pkg::IDX_OUT_W-1:0] alert_index;
        logic                          alert_found;
        logic [srs_pkg::MEAN_W-1:0]    mean_reading;
        logic [srs_pkg::READ_W-1:0]    max_reading;
        logic [srs_pkg::READ_W-1:0]    min_reading;
        logic [srs_pkg::CNT_OUT_W-1:0] error_total;
        logic [srs_pkg::CNT_OUT_W-1:0] valid_total;
    } batch_stats_t;

    // one row of the directed table
    typedef struct packed {
        logic [srs_pkg::READ_W-1:0] reading;
        logic                       is_last;
        logic                       has_want;
        batch_stats_t               want;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [srs_pkg::READ_W-1:0]    s_tdata;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [srs_pkg::OUT_W-1:0]     m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [srs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [srs_pkg::LIMIT_W-1:0]   cfg_data;

    // predictor copy of the limit registers
    logic [srs_pkg::LIMIT_W-1:0] lim_normal;
    logic [srs_pkg::LIMIT_W-1:0] lim_warning;
    logic [srs_pkg::LIMIT_W-1:0] lim_critical;
    logic [srs_pkg::LIMIT_W-1:0] lim_alert;

    // predictor copy of the batch accumulators
    int acc_items;
    int acc_good;
    int acc_bad;
    int acc_sum;
    int acc_min;
    int acc_max;
    int acc_bins [srs_pkg::NUM_BINS];
    int acc_alert_idx;
    bit acc_alert_seen;
    bit acc_overflow;

    batch_stats_t pending_stats [$];
    stim_row_t    stim_rows [$];
    batch_stats_t want_stats;
    batch_stats_t got_stats;
    int           errors = 0;
    bit           calm = 1'b0;
    bit           hold_off_req = 1'b0;

    sensor_reading_statistics u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #400000;
        $display("sensor_reading_statistics: mismatch");
        $finish;
    end

    function automatic batch_stats_t mk_stats(input int valid_n, input int error_n,
                                              input int mn, input int mx, input int mean,
                                              input int found, input int idx,
                                              input int nrm, input int wrn, input int crt,
                                              input int sht, input int ovf);
        batch_stats_t s;
        s.valid_total    = valid_n[srs_pkg::CNT_OUT_W-1:0];
        s.error_total    = error_n[srs_pkg::CNT_OUT_W-1:0];
        s.min_reading    = mn[srs_pkg::READ_W-1:0];
        s.max_reading    = mx[srs_pkg::READ_W-1:0];
        s.mean_reading   = mean[srs_pkg::MEAN_W-1:0];
        s.alert_found    = found[0];
        s.alert_index    = idx[srs_pkg::IDX_OUT_W-1:0];
        s.normal_total   = nrm[srs_pkg::CNT_OUT_W-1:0];
        s.warning_total  = wrn[srs_pkg::CNT_OUT_W-1:0];
        s.critical_total = crt[srs_pkg::CNT_OUT_W-1:0];
        s.shutdown_total = sht[srs_pkg::CNT_OUT_W-1:0];
        s.overflowed     = ovf[0];
        return s;
    endfunction

    task automatic clear_batch();
        acc_items      = 0;
        acc_good       = 0;
        acc_bad        = 0;
        acc_sum        = 0;
        acc_min        = 0;
        acc_max        = 0;
        foreach (acc_bins[i])
            acc_bins[i] = 0;
        acc_alert_idx  = 0;
        acc_alert_seen = 1'b0;
        acc_overflow   = 1'b0;
    endtask

    // fold one accepted reading into the batch, close the batch on last
    task automatic fold_reading(input logic [srs_pkg::READ_W-1:0] raw, input logic is_last,
                                output bit emits, output batch_stats_t res);
        int r;
        r = int'($signed(raw));
        emits = is_last;
        res = '0;
        if (acc_items >= srs_pkg::MAX_READINGS_DEF)
            acc_overflow = 1'b1;
        else
        begin
            // alert check sees every reading within the batch limit, valid or not
            if (!acc_alert_seen && r >= int'(lim_alert))
            begin
                acc_alert_seen = 1'b1;
                acc_alert_idx  = acc_items;
            end
            acc_items++;
            if (r <= 0)
                acc_bad++;
            else
            begin
                if (acc_good == 0 || r < acc_min)
                    acc_min = r;
                if (acc_good == 0 || r > acc_max)
                    acc_max = r;
                acc_good++;
                acc_sum += r;
                // first bin whose limit is not exceeded
                if (r <= int'(lim_normal))
                    acc_bins[srs_pkg::BIN_NORMAL]++;
                else if (r <= int'(lim_warning))
                    acc_bins[srs_pkg::BIN_WARNING]++;
                else if (r <= int'(lim_critical))
                    acc_bins[srs_pkg::BIN_CRITICAL]++;
                else
                    acc_bins[srs_pkg::BIN_SHUTDOWN]++;
            end
        end
        if (is_last)
        begin
            res = mk_stats(acc_good, acc_bad, acc_min, acc_max,
                           (acc_good != 0) ? acc_sum / acc_good : 0,
                           acc_alert_seen, acc_alert_idx,
                           acc_bins[srs_pkg::BIN_NORMAL], acc_bins[srs_pkg::BIN_WARNING],
                           acc_bins[srs_pkg::BIN_CRITICAL], acc_bins[srs_pkg::BIN_SHUTDOWN],
                           acc_overflow);
            clear_batch();
        end
    endtask

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    task automatic check_stats(input batch_stats_t want, input batch_stats_t got);
        check_field("valid_total", want.valid_total, got.valid_total);
        check_field("error_total", want.error_total, got.error_total);
        check_field("min_reading", want.min_reading, got.min_reading);
        check_field("max_reading", want.max_reading, got.max_reading);
        check_field("mean_reading", want.mean_reading, got.mean_reading);
        check_field("alert_found", want.alert_found, got.alert_found);
        check_field("alert_index", want.alert_index, got.alert_index);
        check_field("normal_total", want.normal_total, got.normal_total);
        check_field("warning_total", want.warning_total, got.warning_total);
        check_field("critical_total", want.critical_total, got.critical_total);
        check_field("shutdown_total", want.shutdown_total, got.shutdown_total);
        check_field("overflowed", want.overflowed, got.overflowed);
    endtask

    // offer one reading, called at a falling edge, returns at a falling edge
    task automatic send_reading(input logic [srs_pkg::READ_W-1:0] raw, input logic is_last,
                                input bit has_want, input batch_stats_t want);
        bit           emits;
        batch_stats_t res;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        fold_reading(raw, is_last, emits, res);
        if (emits)
            pending_stats.push_back(has_want ? want : res);
        @(negedge clk);
    endtask

    // wait for every outstanding result, then let the divider settle
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pending_stats.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_limit(input logic [srs_pkg::CFG_IDX_W-1:0] idx,
                               input logic [srs_pkg::LIMIT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            srs_pkg::CFG_NORMAL:   lim_normal   = val;
            srs_pkg::CFG_WARNING:  lim_warning  = val;
            srs_pkg::CFG_CRITICAL: lim_critical = val;
            srs_pkg::CFG_ALERT:    lim_alert    = val;
            default:               ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_limits(input int nrm, input int wrn, input int crt, input int alr);
        write_limit(srs_pkg::CFG_NORMAL, nrm[srs_pkg::LIMIT_W-1:0]);
        write_limit(srs_pkg::CFG_WARNING, wrn[srs_pkg::LIMIT_W-1:0]);
        write_limit(srs_pkg::CFG_CRITICAL, crt[srs_pkg::LIMIT_W-1:0]);
        write_limit(srs_pkg::CFG_ALERT, alr[srs_pkg::LIMIT_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [srs_pkg::READ_W-1:0] clamp_reading(input int v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[srs_pkg::READ_W-1:0];
    endfunction

    // random reading, weighted toward the limits and the error range
    function automatic logic [srs_pkg::READ_W-1:0] pick_reading();
        int v;
        case ($urandom_range(0, 9))
            0: v = -int'($urandom_range(0, 32768));
            1: v = 0;
            2, 3, 4, 5:
            begin
                case ($urandom_range(0, 3))
                    0:       v = int'(lim_normal);
                    1:       v = int'(lim_warning);
                    2:       v = int'(lim_critical);
                    default: v = int'(lim_alert);
                endcase
                v += int'($urandom_range(0, 4)) - 2;
            end
            6:       v = int'($urandom_range(1, 16));
            default: v = int'($signed(16'($urandom_range(0, 65535))));
        endcase
        return clamp_reading(v);
    endfunction

    task automatic run_batches(input int target);
        int sent;
        int len;
        sent = 0;
        while (sent < target)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_reading(pick_reading(), i == len - 1, 1'b0, '0);
            sent += len;
        end
    endtask

    // batch past MAX_READINGS with the first alert reading at a chosen index
    task automatic send_long_batch(input bit alert_inside);
        int len;
        int alert_at;
        int v;
        len = srs_pkg::MAX_READINGS_DEF + $urandom_range(1, 10);
        alert_at = alert_inside ? srs_pkg::MAX_READINGS_DEF - 1
                                : srs_pkg::MAX_READINGS_DEF +
                                  $urandom_range(0, len - srs_pkg::MAX_READINGS_DEF - 1);
        for (int i = 0; i < len; i++)
        begin
            if (i < alert_at)
                v = int'(lim_alert) - 1 - int'($urandom_range(0, 2000));
            else if (i == alert_at)
                v = int'(lim_alert) + int'($urandom_range(0, 100));
            else
                v = int'($signed(pick_reading()));
            send_reading(clamp_reading(v), i == len - 1, 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_stats = batch_stats_t'(m_tdata);
            if (pending_stats.size() == 0)
            begin
                $display("%0t: result with none expected, expected none actual %h",
                         $time, m_tdata);
                errors++;
            end
            else
            begin
                want_stats = pending_stats.pop_front();
                check_stats(want_stats, got_stats);
            end
        end
    end

    // result side: random stalls and one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                for (int n = 0; n < 150; n++)
                    @(negedge clk);
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = srs_pkg::CFG_NORMAL;
        cfg_data  = '0;
        lim_normal   = srs_pkg::NORMAL_RST;
        lim_warning  = srs_pkg::WARNING_RST;
        lim_critical = srs_pkg::CRITICAL_RST;
        lim_alert    = srs_pkg::ALERT_RST;
        clear_batch();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table under the reset limits
        stim_rows.push_back({16'h0000, 1'b1, 1'b1, mk_stats(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        stim_rows.push_back({16'h8000, 1'b1, 1'b1, mk_stats(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        stim_rows.push_back({16'hFFFF, 1'b1, 1'b1, mk_stats(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
        stim_rows.push_back({16'h7FFF, 1'b1, 1'b1,
                             mk_stats(1, 0, 32767, 32767, 32767, 1, 0, 0, 0, 0, 1, 0)});
        stim_rows.push_back({16'h0001, 1'b1, 1'b1, mk_stats(1, 0, 1, 1, 1, 0, 0, 1, 0, 0, 0, 0)});
        // each limit and one past it, and the alert limit with one below it
        stim_rows.push_back({16'd480, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd481, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd640, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd641, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd719, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd720, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd960, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd961, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'hFFF0, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd100, 1'b1, 1'b0, 104'd0});
        stim_rows.push_back({16'd1000, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd2, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'd30000, 1'b1, 1'b0, 104'd0});
        // largest two-reading sum for the mean
        stim_rows.push_back({16'h7FFF, 1'b0, 1'b0, 104'd0});
        stim_rows.push_back({16'h7FFF, 1'b1, 1'b0, 104'd0});
        foreach (stim_rows[i])
            send_reading(stim_rows[i].reading, stim_rows[i].is_last,
                         stim_rows[i].has_want, stim_rows[i].want);
        quiesce();

        // random phases, each under its own limits
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: set_limits(0, 0, 0, 0);
                1: set_limits(32767, 32767, 32767, 32767);
                2: set_limits($urandom_range(0, 800), $urandom_range(800, 2000),
                              $urandom_range(2000, 32767), $urandom_range(0, 32767));
                3: set_limits($urandom_range(0, 32767), $urandom_range(0, 32767),
                              $urandom_range(0, 32767), $urandom_range(0, 32767));
                default:
                begin
                    set_limits(srs_pkg::NORMAL_RST, srs_pkg::WARNING_RST,
                               srs_pkg::CRITICAL_RST, srs_pkg::ALERT_RST);
                    calm = 1'b1;
                end
            endcase
            // long receiver hold-off while readings keep coming
            if (phase == 1)
                hold_off_req = 1'b1;
            run_batches(20);
            if (phase == 1)
                send_long_batch(1'b1);
            if (phase == 3)
                send_long_batch(1'b0);
            run_batches(5);
            quiesce();
        end

        if (errors == 0)
            $display("sensor_reading_statistics: match");
        else
            $display("sensor_reading_statistics: mismatch");
        $finish;
    end

endmodule
